// ===== rtl/rabs_pkg.sv =====
// Shared types, codes and reset constants for the register ALU branch step block.
package rabs_pkg;

  localparam int REG_COUNT_DEF   = 32;
  localparam int LABEL_SLOTS_DEF = 5;
  localparam int PC_WIDTH_DEF    = 8;

  localparam int IDX_W       = 5;
  localparam int IDX_SPAN    = 1 << IDX_W;
  localparam int DATA_W      = 32;
  localparam int LABEL_REGS  = 5;
  localparam int LABEL_W     = 8;
  localparam int LCOUNT_W    = 3;
  localparam int LIDX_W      = 3;
  localparam int NEXT_PC_W   = 8;
  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 32;

  localparam logic [LCOUNT_W-1:0] VALID_LABELS_RESET = 3'd5;
  localparam logic [LABEL_W-1:0]  LABEL_RESET [LABEL_REGS] = '{8'd4, 8'd24, 8'd28, 8'd16, 8'd32};

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_ADDI = 4'd3,
    OP_BEQ  = 4'd4,
    OP_BGT  = 4'd5,
    OP_BLE  = 4'd6,
    OP_J    = 4'd7,
    OP_NEG  = 4'd8
  } rabs_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_LABEL = 2'd1,
    ST_BAD_OP   = 2'd2
  } rabs_status_e;

  typedef enum logic [2:0] {
    CFG_VALID_LABELS = 3'd0,
    CFG_LABEL_ADDR0  = 3'd1
  } rabs_cfg_e;

  typedef struct packed {
    rabs_status_e               status;
    logic [NEXT_PC_W-1:0]       next_pc;
    logic                       wrote;
    logic [IDX_W-1:0]           write_index;
    logic signed [DATA_W-1:0]   write_value;
    logic                       taken;
  } rabs_res_t;

endpackage

// ===== rtl/rabs_regfile.sv =====
// Register file memory with reset-by-index valid bits and write-to-read forwarding.
module rabs_regfile #(
  parameter int REG_COUNT = rabs_pkg::REG_COUNT_DEF,
  localparam int AW = $clog2(REG_COUNT)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               rd_en_i,
  input  logic [AW-1:0]                      rd_addr_a_i,
  input  logic [AW-1:0]                      rd_addr_b_i,
  output logic signed [rabs_pkg::DATA_W-1:0] rd_data_a_o,
  output logic signed [rabs_pkg::DATA_W-1:0] rd_data_b_o,
  input  logic                               wr_en_i,
  input  logic [AW-1:0]                      wr_addr_i,
  input  logic signed [rabs_pkg::DATA_W-1:0] wr_data_i
);
  import rabs_pkg::*;

  logic [DATA_W-1:0]    rf_mem_q [REG_COUNT];
  logic [REG_COUNT-1:0] valid_q;
  logic [DATA_W-1:0]    rdata_a_q, rdata_b_q, fwd_data_q;
  logic [AW-1:0]        addr_a_q, addr_b_q;
  logic                 hit_a_q, hit_b_q, vld_a_q, vld_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      rf_mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_a_q  <= rf_mem_q[rd_addr_a_i];
      rdata_b_q  <= rf_mem_q[rd_addr_b_i];
      addr_a_q   <= rd_addr_a_i;
      addr_b_q   <= rd_addr_b_i;
      fwd_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_a_q <= wr_en_i && (wr_addr_i == rd_addr_a_i);
        hit_b_q <= wr_en_i && (wr_addr_i == rd_addr_b_i);
        vld_a_q <= valid_q[rd_addr_a_i];
        vld_b_q <= valid_q[rd_addr_b_i];
      end
    end
  end

  assign rd_data_a_o = hit_a_q ? fwd_data_q : (vld_a_q ? rdata_a_q : DATA_W'(addr_a_q));
  assign rd_data_b_o = hit_b_q ? fwd_data_q : (vld_b_q ? rdata_b_q : DATA_W'(addr_b_q));

endmodule

// ===== rtl/rabs_cfg.sv =====
// Configuration register bank holding the label count and label address table.
module rabs_cfg #(
  parameter int LABEL_SLOTS = rabs_pkg::LABEL_SLOTS_DEF,
  localparam int LabelStore =
    (LABEL_SLOTS < rabs_pkg::LABEL_REGS) ? LABEL_SLOTS : rabs_pkg::LABEL_REGS
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          psel,
  input  logic                                          penable,
  input  logic                                          pwrite,
  input  logic [rabs_pkg::CFG_ADDR_W-1:0]               paddr,
  input  logic [rabs_pkg::CFG_DATA_W-1:0]               pwdata,
  output logic [rabs_pkg::CFG_DATA_W-1:0]               prdata,
  output logic [rabs_pkg::LCOUNT_W-1:0]                 valid_labels_o,
  output logic [LabelStore-1:0][rabs_pkg::LABEL_W-1:0]  label_addr_o
);
  import rabs_pkg::*;

  logic [LCOUNT_W-1:0]                count_q;
  logic [LabelStore-1:0][LABEL_W-1:0] addr_q;
  logic [2:0]                         reg_idx;
  logic                               wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= VALID_LABELS_RESET;
      for (int i = 0; i < LabelStore; i++) begin
        addr_q[i] <= LABEL_RESET[i];
      end
    end else if (wr_en) begin
      if (reg_idx == CFG_VALID_LABELS) begin
        count_q <= pwdata[LCOUNT_W-1:0];
      end
      for (int i = 0; i < LabelStore; i++) begin
        if (reg_idx == 3'(CFG_LABEL_ADDR0) + 3'(i)) begin
          addr_q[i] <= pwdata[LABEL_W-1:0];
        end
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == CFG_VALID_LABELS) begin
      prdata = CFG_DATA_W'(count_q);
    end
    for (int i = 0; i < LabelStore; i++) begin
      if (reg_idx == 3'(CFG_LABEL_ADDR0) + 3'(i)) begin
        prdata = CFG_DATA_W'(addr_q[i]);
      end
    end
  end

  assign valid_labels_o = count_q;
  assign label_addr_o   = addr_q;

endmodule

// ===== rtl/rabs_exec.sv =====
// Execute stage: arithmetic, branch compare, label lookup and next program counter.
module rabs_exec #(
  parameter int LABEL_SLOTS = rabs_pkg::LABEL_SLOTS_DEF,
  parameter int PC_WIDTH    = rabs_pkg::PC_WIDTH_DEF,
  localparam int LabelStore =
    (LABEL_SLOTS < rabs_pkg::LABEL_REGS) ? LABEL_SLOTS : rabs_pkg::LABEL_REGS
) (
  input  logic [3:0]                                    mode_i,
  input  logic [rabs_pkg::IDX_W-1:0]                    dest_i,
  input  logic signed [rabs_pkg::DATA_W-1:0]            immediate_i,
  input  logic [rabs_pkg::LIDX_W-1:0]                   label_index_i,
  input  logic signed [rabs_pkg::DATA_W-1:0]            op_a_i,
  input  logic signed [rabs_pkg::DATA_W-1:0]            op_b_i,
  input  logic [PC_WIDTH-1:0]                           pc_i,
  input  logic [rabs_pkg::LCOUNT_W-1:0]                 valid_labels_i,
  input  logic [LabelStore-1:0][rabs_pkg::LABEL_W-1:0]  label_addr_i,
  output logic [PC_WIDTH-1:0]                           pc_o,
  output rabs_pkg::rabs_res_t                           res_o
);
  import rabs_pkg::*;

  rabs_op_e            op;
  logic [LCOUNT_W-1:0] lim;
  logic                found, cond, is_branch;
  logic [LABEL_W-1:0]  target;
  logic [DATA_W-1:0]   alu;
  logic [PC_WIDTH-1:0] pc_inc;

  assign op     = rabs_op_e'(mode_i);
  assign lim    = (valid_labels_i < LCOUNT_W'(LabelStore)) ? valid_labels_i
                                                           : LCOUNT_W'(LabelStore);
  assign found  = label_index_i < lim;
  assign pc_inc = pc_i + PC_WIDTH'(1);

  always_comb begin
    target = '0;
    for (int i = 0; i < LabelStore; i++) begin
      if (label_index_i == LIDX_W'(i)) begin
        target = label_addr_i[i];
      end
    end
  end

  always_comb begin
    alu       = '0;
    cond      = 1'b0;
    is_branch = 1'b0;
    res_o     = '0;
    pc_o      = pc_i;
    case (op)
      OP_ADD:  alu = op_a_i + op_b_i;
      OP_SUB:  alu = op_a_i - op_b_i;
      OP_MUL:  alu = op_a_i * op_b_i;
      OP_ADDI: alu = op_a_i + immediate_i;
      OP_NEG:  alu = -op_a_i;
      OP_BEQ:  begin is_branch = 1'b1; cond = (op_a_i == op_b_i); end
      OP_BGT:  begin is_branch = 1'b1; cond = (op_a_i > op_b_i); end
      OP_BLE:  begin is_branch = 1'b1; cond = (op_a_i <= op_b_i); end
      OP_J:    begin is_branch = 1'b1; cond = 1'b1; end
      default: res_o.status = ST_BAD_OP;
    endcase
    if (op == OP_ADD || op == OP_SUB || op == OP_MUL || op == OP_ADDI || op == OP_NEG) begin
      res_o.wrote       = 1'b1;
      res_o.write_index = dest_i;
      res_o.write_value = alu;
      pc_o              = pc_inc;
    end else if (is_branch) begin
      if (!found) begin
        res_o.status = ST_NO_LABEL;
      end else if (cond) begin
        res_o.taken = 1'b1;
        pc_o        = PC_WIDTH'(target);
      end else begin
        pc_o = pc_inc;
      end
    end
    res_o.next_pc = NEXT_PC_W'(pc_o);
  end

endmodule

// ===== rtl/register_alu_branch_step.sv =====
// Top level of the register ALU branch step: decode, register file read, execute, output.
//
//  channel   dir  transfer when                      payload
//  s_axis    in   s_axis_tvalid & s_axis_tready     tdata: dest, src_a, src_b, imm, label
//  m_axis    out  m_axis_tvalid & m_axis_tready     tdata: next_pc, wrote, windex, wvalue, taken
//  apb       in   psel & penable & pwrite & pready  label count and label address table
//
// One instruction per cycle while the output is not stalled. An instruction is accepted
// and reads both operands from the register file memory into registers, then executes
// and writes back when it leaves the execute stage; its result is registered for output.
// A write in the same cycle as the following read is forwarded.
// Reset clears the valid bits; an unwritten register reads as its own index, so no sweep.
// A stalled output holds the execute stage; one more input is taken while the result
// waits, then the input stalls.
module register_alu_branch_step #(
  parameter int REG_COUNT   = rabs_pkg::REG_COUNT_DEF,
  parameter int LABEL_SLOTS = rabs_pkg::LABEL_SLOTS_DEF,
  parameter int PC_WIDTH    = rabs_pkg::PC_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // dest_index[4:0], src_a_index[9:5], src_b_index[14:10], immediate[46:15],
  // label_index[49:47], zero fill above
  input  logic [55:0]                       s_axis_tdata,
  // mode[3:0]
  input  logic [3:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // next_pc[7:0], wrote[8], write_index[13:9], write_value[45:14], taken[46], zero fill
  output logic [47:0]                       m_axis_tdata,
  // status[1:0]
  output logic [1:0]                        m_axis_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rabs_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [rabs_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rabs_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import rabs_pkg::*;

  localparam int AW = $clog2(REG_COUNT);
  localparam int LabelStore = (LABEL_SLOTS < LABEL_REGS) ? LABEL_SLOTS : LABEL_REGS;

  logic [IDX_W-1:0] sel_tab [IDX_SPAN];

  for (genvar g = 0; g < IDX_SPAN; g++) begin : g_sel
    assign sel_tab[g] = IDX_W'(g % REG_COUNT);
  end

  logic                          in_xfer, s1_fire;
  logic                          s1_valid_q, m_valid_q;
  logic [3:0]                    s1_mode_q;
  logic [IDX_W-1:0]              s1_dest_q;
  logic signed [DATA_W-1:0]      s1_imm_q;
  logic [LIDX_W-1:0]             s1_label_q;
  logic [IDX_W-1:0]              src_a, src_b;
  logic signed [DATA_W-1:0]      op_a, op_b;
  logic [PC_WIDTH-1:0]           pc_q, pc_d;
  logic [LCOUNT_W-1:0]           valid_labels;
  logic [LabelStore-1:0][LABEL_W-1:0] label_addr;
  rabs_res_t                     res, res_q;
  logic                          wr_en;

  assign src_a = sel_tab[s_axis_tdata[9:5]];
  assign src_b = sel_tab[s_axis_tdata[14:10]];

  assign s1_fire       = s1_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign wr_en         = s1_fire && res.wrote;

  rabs_cfg #(
    .LABEL_SLOTS (LABEL_SLOTS)
  ) u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .valid_labels_o (valid_labels),
    .label_addr_o   (label_addr)
  );

  rabs_regfile #(
    .REG_COUNT (REG_COUNT)
  ) u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_xfer),
    .rd_addr_a_i (AW'(src_a)),
    .rd_addr_b_i (AW'(src_b)),
    .rd_data_a_o (op_a),
    .rd_data_b_o (op_b),
    .wr_en_i     (wr_en),
    .wr_addr_i   (AW'(res.write_index)),
    .wr_data_i   (res.write_value)
  );

  rabs_exec #(
    .LABEL_SLOTS (LABEL_SLOTS),
    .PC_WIDTH    (PC_WIDTH)
  ) u_exec (
    .mode_i         (s1_mode_q),
    .dest_i         (s1_dest_q),
    .immediate_i    (s1_imm_q),
    .label_index_i  (s1_label_q),
    .op_a_i         (op_a),
    .op_b_i         (op_b),
    .pc_i           (pc_q),
    .valid_labels_i (valid_labels),
    .label_addr_i   (label_addr),
    .pc_o           (pc_d),
    .res_o          (res)
  );

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_mode_q  <= s_axis_tuser;
      s1_dest_q  <= sel_tab[s_axis_tdata[4:0]];
      s1_imm_q   <= s_axis_tdata[46:15];
      s1_label_q <= s_axis_tdata[49:47];
    end
    if (s1_fire) begin
      res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      pc_q       <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        m_valid_q <= 1'b1;
        pc_q      <= pc_d;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = res_q.status;
  assign m_axis_tdata  = {1'b0, res_q.taken, res_q.write_value, res_q.write_index,
                          res_q.wrote, res_q.next_pc};
  assign pready        = 1'b1;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && m_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while execute stage is stalled");

  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(s1_fire))
    else $error("result appeared without an executed instruction");

  a_pc_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(pc_q))
    else $error("program counter moved without an executed instruction");

  a_taken_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && res_q.taken |-> res_q.status == ST_OK && !res_q.wrote)
    else $error("taken branch reports a write or an error");

endmodule
